// ----- rtl/core/key_click_hold_event_detector_unit_assert.svh -----
// Assertion macros shared by the key click and hold event detector RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef KEY_CLICK_HOLD_EVENT_DETECTOR_UNIT_ASSERT_SVH
`define KEY_CLICK_HOLD_EVENT_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define KCHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KCHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kchd_pkg.sv -----
// Shared types and constants for the key click and hold event detector.
// No dependencies; imported by every module of the block.
package kchd_pkg;

  // Per-key mode codes
  typedef enum logic [2:0] {
    MODE_RELEASE    = 3'd0,
    MODE_PREPRESS   = 3'd1,
    MODE_PRELONG    = 3'd2,
    MODE_LONGHOLD   = 3'd3,
    MODE_MULTICLICK = 3'd4
  } kchd_mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_POLL_PERIOD   = 3'd0,
    CFG_CLICK_THR     = 3'd1,
    CFG_HOLD_THR      = 3'd2,
    CFG_REPEAT_PERIOD = 3'd3,
    CFG_GAP_LIMIT     = 3'd4
  } kchd_cfg_idx_t;

  localparam int unsigned KEY_W    = 3;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned CFG_W    = 16;

  localparam logic [PERIOD_W-1:0] POLL_PERIOD_RST   = 8'd1;
  localparam logic [THR_W-1:0]    CLICK_THR_RST     = 16'd20;
  localparam logic [THR_W-1:0]    HOLD_THR_RST      = 16'd1000;
  localparam logic [THR_W-1:0]    REPEAT_PERIOD_RST = 16'd200;
  localparam logic [THR_W-1:0]    GAP_LIMIT_RST     = 16'd300;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  // Event flags of one tick
  typedef struct packed {
    logic release_ev;
    logic multi_click;
    logic long_hold_end;
    logic hold_repeat;
    logic first_long;
    logic press;
  } kchd_evt_t;

  // Configuration values handed to the update logic
  typedef struct packed {
    logic [PERIOD_W-1:0] poll_period;
    logic [THR_W-1:0]    click_thr;
    logic [THR_W-1:0]    hold_thr;
    logic [THR_W-1:0]    repeat_period;
    logic [THR_W-1:0]    gap_limit;
  } kchd_cfg_t;

endpackage

// ----- rtl/core/kchd_state_ram.sv -----
// Per-key state memory: one write port, one registered read port.
// Entries carry valid bits so unwritten keys read as the all-zero reset record.
module kchd_state_ram import kchd_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 75,
  parameter int unsigned AW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_q_r;
  logic             rd_vld_r;

  // Storage array write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Valid bits: cleared at reset, set on first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- rtl/core/kchd_update.sv -----
// Next-state logic for one key: mode machine, timers, click count, events.
// Depends on kchd_pkg for mode codes, event and configuration structs.
module kchd_update import kchd_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  kchd_cfg_t             cfg,
  input  logic                  pressed,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [TIMER_BITS-1:0] press_i,
  input  logic [TIMER_BITS-1:0] gap_i,
  input  logic [TIMER_BITS-1:0] rep_i,
  input  logic [CNT_W-1:0]      cnt_i,
  input  logic [TIMER_BITS-1:0] hold_i,
  output logic [MODE_W-1:0]     mode_o,
  output logic [TIMER_BITS-1:0] press_o,
  output logic [TIMER_BITS-1:0] gap_o,
  output logic [TIMER_BITS-1:0] rep_o,
  output logic [CNT_W-1:0]      cnt_o,
  output logic [TIMER_BITS-1:0] hold_o,
  output kchd_evt_t             evt
);

  localparam int unsigned CW = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;

  logic [TIMER_BITS:0]   press_sum;
  logic [TIMER_BITS:0]   gap_sum;
  logic [TIMER_BITS-1:0] press_sat;
  logic [TIMER_BITS-1:0] gap_sat;
  logic [TIMER_BITS-1:0] press_n;
  logic [TIMER_BITS-1:0] gap_n;
  logic [TIMER_BITS-1:0] reload;
  logic [TIMER_BITS-1:0] pp_t;
  logic                  over_click;
  logic                  over_hold;
  logic                  over_gap;
  kchd_mode_t            mode_n;

  // Saturating timer advance
  assign pp_t      = TIMER_BITS'(cfg.poll_period);
  assign press_sum = {1'b0, press_i} + (TIMER_BITS + 1)'(cfg.poll_period);
  assign gap_sum   = {1'b0, gap_i} + (TIMER_BITS + 1)'(cfg.poll_period);
  assign press_sat = press_sum[TIMER_BITS] ? '1 : press_sum[TIMER_BITS-1:0];
  assign gap_sat   = gap_sum[TIMER_BITS] ? '1 : gap_sum[TIMER_BITS-1:0];
  assign press_n   = pressed ? press_sat : '0;
  assign gap_n     = (mode_i == MODE_MULTICLICK) ? gap_sat : '0;
  assign reload    = TIMER_BITS'(cfg.repeat_period);

  // Threshold compares at a common width
  assign over_click = CW'(press_n) > CW'(cfg.click_thr);
  assign over_hold  = CW'(press_n) > CW'(cfg.hold_thr);
  assign over_gap   = CW'(gap_n) > CW'(cfg.gap_limit);

  // Mode machine
  always_comb begin
    mode_n = MODE_RELEASE;
    rep_o  = rep_i;
    cnt_o  = cnt_i;
    evt    = '0;
    case (mode_i)
      MODE_PREPRESS: begin
        mode_n = MODE_PREPRESS;
        if (!pressed) begin
          mode_n = MODE_RELEASE;
        end else if (over_click) begin
          mode_n    = MODE_PRELONG;
          evt.press = 1'b1;
        end
      end
      MODE_PRELONG: begin
        mode_n = MODE_PRELONG;
        if (!pressed) begin
          mode_n = MODE_MULTICLICK;
          if (cnt_i != CNT_MAX) begin
            cnt_o = cnt_i + CNT_W'(1);
          end
        end else if (over_hold) begin
          mode_n         = MODE_LONGHOLD;
          rep_o          = reload;
          evt.first_long = 1'b1;
        end
      end
      MODE_LONGHOLD: begin
        mode_n = MODE_LONGHOLD;
        // repeat countdown clamps at zero, reloads and fires once empty
        if (rep_i != '0) begin
          rep_o = (rep_i > pp_t) ? (rep_i - pp_t) : '0;
        end else begin
          rep_o           = reload;
          evt.hold_repeat = 1'b1;
        end
        if (!pressed) begin
          evt.long_hold_end = 1'b1;
          evt.release_ev    = 1'b1;
          mode_n            = MODE_RELEASE;
        end
      end
      MODE_MULTICLICK: begin
        mode_n = MODE_MULTICLICK;
        if (over_gap) begin
          evt.multi_click = 1'b1;
          evt.release_ev  = 1'b1;
          mode_n          = MODE_RELEASE;
        end else if (over_click) begin
          mode_n = MODE_PRELONG;
        end
      end
      default: begin
        // release, and any unused code
        cnt_o  = '0;
        mode_n = pressed ? MODE_PREPRESS : MODE_RELEASE;
      end
    endcase
  end

  assign mode_o  = mode_n;
  assign press_o = press_n;
  assign gap_o   = gap_n;
  assign hold_o  = (!pressed && mode_i == MODE_LONGHOLD) ? press_i : hold_i;

endmodule

// ----- rtl/core/key_click_hold_event_detector_unit.sv -----
// Key click / long-press event detector, top level.
// Input channel (in_t*): one polling tick per word; in_tdata[2:0] key index,
//   in_tdata[3] pressed level. Ticks for keys at or above NUM_KEYS are dropped.
// Output channel (out_t*): one event word per tick of a valid key, in order.
// Configuration: cfg_wen writes cfg_wdata to register cfg_addr (0 poll period,
//   1 click threshold, 2 hold threshold, 3 repeat period, 4 gap limit).
// Throughput: one tick per cycle while out_tready keeps the output flowing.
//   The key record is read from the state memory at the accepting edge,
//   updated in the update stage and loaded into the output register
//   together with the write-back once the output word can be replaced.
// A record written back in the same cycle the next tick of that key is read
//   is forwarded, so ticks of one key may follow each other back to back.
// Reset (rst_n low, synchronous): all keys return to release with cleared
//   timers and counts via per-entry valid bits, registers take their defaults,
//   both channels go empty; no clearing pass is needed.
// Stall: while out_tready is low the output word holds, one further tick
//   waits in the update stage and in_tready drops until the word is taken.
// Depends on kchd_pkg, kchd_state_ram, kchd_update.
`include "key_click_hold_event_detector_unit_assert.svh"
module key_click_hold_event_detector_unit import kchd_pkg::*; #(
  parameter int unsigned NUM_KEYS   = 8,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input: [2:0] key_index, [3] pressed, [7:4] zero
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  // output: [2:0] event_key, [3] press_event, [4] first_long_event,
  // [5] hold_repeat_event, [6] long_hold_end_event, [7] multi_click_event,
  // [8] release_event, [16:9] clicks_seen, [32:17] last_hold_time,
  // [35:33] key_state, [39:36] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,
  // configuration write port
  input  logic                  cfg_wen,
  input  logic [2:0]            cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int unsigned AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned T     = TIMER_BITS;
  localparam int unsigned REC_W = MODE_W + 4 * T + CNT_W;
  localparam int unsigned HW    = (T > HOLD_W) ? T : HOLD_W;

  // record layout, low to high: mode, press, gap, repeat, count, hold
  localparam int unsigned PRESS_LSB = MODE_W;
  localparam int unsigned GAP_LSB   = PRESS_LSB + T;
  localparam int unsigned REP_LSB   = GAP_LSB + T;
  localparam int unsigned CNT_LSB   = REP_LSB + T;
  localparam int unsigned HOLD_LSB  = CNT_LSB + CNT_W;

  kchd_cfg_t        cfg_r;
  logic             in_acc;
  logic [KEY_W-1:0] in_key;
  logic             in_range;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [REC_W-1:0] rd_data;

  logic             s1_valid_r;
  logic [KEY_W-1:0] s1_key_r;
  logic             s1_p_r;
  logic             s1_inr_r;
  logic             s1_adv;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [REC_W-1:0] wr_data;
  logic             fwd_hit_r;
  logic [REC_W-1:0] fwd_data_r;
  logic [REC_W-1:0] rec;

  logic [MODE_W-1:0] mode_n;
  logic [T-1:0]      press_n;
  logic [T-1:0]      gap_n;
  logic [T-1:0]      rep_n;
  logic [CNT_W-1:0]  cnt_n;
  logic [T-1:0]      hold_n;
  kchd_evt_t         evt;
  logic [HW-1:0]     hold_w;

  logic              out_tvalid_r;
  logic [39:0]       out_tdata_r;
  logic [39:0]       out_tdata_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_period   <= POLL_PERIOD_RST;
      cfg_r.click_thr     <= CLICK_THR_RST;
      cfg_r.hold_thr      <= HOLD_THR_RST;
      cfg_r.repeat_period <= REPEAT_PERIOD_RST;
      cfg_r.gap_limit     <= GAP_LIMIT_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_POLL_PERIOD:   cfg_r.poll_period   <= cfg_wdata[PERIOD_W-1:0];
        CFG_CLICK_THR:     cfg_r.click_thr     <= cfg_wdata[THR_W-1:0];
        CFG_HOLD_THR:      cfg_r.hold_thr      <= cfg_wdata[THR_W-1:0];
        CFG_REPEAT_PERIOD: cfg_r.repeat_period <= cfg_wdata[THR_W-1:0];
        CFG_GAP_LIMIT:     cfg_r.gap_limit     <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept stage: issue the memory read for in-range keys
  assign in_key   = in_tdata[KEY_W-1:0];
  assign in_range = int'(in_key) < NUM_KEYS;
  assign in_acc   = in_tvalid && in_tready;
  assign rd_en    = in_acc && in_range;
  assign rd_addr  = AW'(in_key);

  // Update stage handshake: out-of-range ticks drop right away
  assign wr_en     = s1_valid_r && s1_inr_r && (!out_tvalid_r || out_tready);
  assign s1_adv    = s1_valid_r && (!s1_inr_r || !out_tvalid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign wr_addr   = AW'(s1_key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (rd_en) begin
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_key_r <= in_key;
      s1_p_r   <= in_tdata[KEY_W];
      s1_inr_r <= in_range;
    end
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  // State memory
  kchd_state_ram #(
    .DEPTH (NUM_KEYS),
    .WIDTH (REC_W),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Forward the record written while this key was being read
  assign rec = fwd_hit_r ? fwd_data_r : rd_data;

  kchd_update #(
    .TIMER_BITS (T)
  ) u_update (
    .cfg     (cfg_r),
    .pressed (s1_p_r),
    .mode_i  (rec[MODE_W-1:0]),
    .press_i (rec[PRESS_LSB +: T]),
    .gap_i   (rec[GAP_LSB +: T]),
    .rep_i   (rec[REP_LSB +: T]),
    .cnt_i   (rec[CNT_LSB +: CNT_W]),
    .hold_i  (rec[HOLD_LSB +: T]),
    .mode_o  (mode_n),
    .press_o (press_n),
    .gap_o   (gap_n),
    .rep_o   (rep_n),
    .cnt_o   (cnt_n),
    .hold_o  (hold_n),
    .evt     (evt)
  );

  assign wr_data = {hold_n, cnt_n, rep_n, gap_n, press_n, mode_n};
  assign hold_w  = HW'(hold_n);

  // Output word packing
  always_comb begin
    out_tdata_nxt        = '0;
    out_tdata_nxt[2:0]   = s1_key_r;
    out_tdata_nxt[3]     = evt.press;
    out_tdata_nxt[4]     = evt.first_long;
    out_tdata_nxt[5]     = evt.hold_repeat;
    out_tdata_nxt[6]     = evt.long_hold_end;
    out_tdata_nxt[7]     = evt.multi_click;
    out_tdata_nxt[8]     = evt.release_ev;
    out_tdata_nxt[16:9]  = cnt_n;
    out_tdata_nxt[32:17] = hold_w[HOLD_W-1:0];
    out_tdata_nxt[35:33] = mode_n;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (wr_en) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  `KCHD_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, s1_valid_r && !s1_adv, !in_tready, "input taken while update stage stalled")
  `KCHD_ASSERT_NXT(a_read_enters_stage, clk, rst_n, rd_en, s1_valid_r && s1_inr_r, "memory read without a tick in the update stage")
  `KCHD_ASSERT_IMP(a_out_from_write, clk, rst_n, $rose(out_tvalid_r), $past(wr_en), "output word without a record write-back")

endmodule
